>>> hdl/assert_macros.svh
// Assertion macros used by the SHA-256 hash engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Property that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`endif

>>> hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;
  localparam int BLOCK_WORDS = 16;
  localparam int CHAIN_WORDS = 8;
  localparam int ROUNDS = 64;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction
endpackage

>>> hdl/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Hashes a byte stream and returns the 256-bit digest as four 64-bit words.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry msg_byte, has_byte, end_of_message.
// Each byte is packed into a 32-bit word of a 16-entry message RAM. When the
// 64th byte arrives, the 64-round compression runs, one round per cycle,
// reading the block words from that RAM; the schedule is kept in registers.
// The input is stalled until the compression has finished.
// The input is also stalled while the padding runs.
// An end flag pads the block (one or two compressions) and then presents
// four digest words on out_valid/out_stall, most significant first. The first
// word appears once the padding and its compressions are done. A stall from
// the receiver holds the current word; no input is taken until all four words
// have gone and ST_LAST has put the chaining state back to the initial values.
// Reset (rst, synchronous) empties the buffer and loads the initial values;
// the message RAM needs no clearing since padding writes every unused word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_hash_engine
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  msg_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);
  localparam int AW = $clog2(BLOCK_WORDS);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PAD  = 7'b0000010,
    ST_PRE  = 7'b0000100,
    ST_RND  = 7'b0001000,
    ST_ADD  = 7'b0010000,
    ST_OUT  = 7'b0100000,
    ST_LAST = 7'b1000000
  } state_t;

  state_t      state;
  logic [31:0] chain [CHAIN_WORDS];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [5:0]  fill;
  logic [63:0] msg_len;
  logic [23:0] partial;
  logic [6:0]  rnd;
  logic        final_pending;
  logic        len_block;
  logic [3:0]  pad_idx;
  logic [1:0]  out_idx;
  logic [31:0] w_hist [BLOCK_WORDS];
  logic        pad_done_flag;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  sha_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_msg_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic        in_fire;
  logic [31:0] byte_word;
  logic [31:0] w_cur;
  logic [31:0] t1, t2;
  logic [63:0] bit_len;
  logic [5:0]  r6;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign byte_word = {partial, msg_byte};
  assign bit_len   = {msg_len[60:0], 3'b000};
  assign r6        = rnd[5:0];

  // The schedule history is kept in registers so rounds 16..63 need no
  // extra read ports; the RAM holds the raw block words for the first 16.
  always_comb begin
    if (rnd < 7'd16) begin
      w_cur = rdata;
    end else begin
      w_cur = sig1(w_hist[14]) + w_hist[9] + sig0(w_hist[1]) + w_hist[0];
    end
  end

  assign t1 = vh + bsig1(ve) + ((ve & vf) ^ (~ve & vg)) + ROUND_K[r6] + w_cur;
  assign t2 = bsig0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));

  always_comb begin
    we    = 1'b0;
    waddr = fill[5:2];
    wdata = byte_word;
    raddr = '0;
    if (state == ST_IDLE && in_fire && has_byte && fill[1:0] == 2'b11) begin
      we = 1'b1;
    end
    if (state == ST_PAD) begin
      we    = 1'b1;
      waddr = pad_idx;
      if (!len_block && pad_idx == fill[5:2]) begin
        case (fill[1:0])
          2'd0:    wdata = {PAD_BYTE, 24'h0};
          2'd1:    wdata = {partial[7:0], PAD_BYTE, 16'h0};
          2'd2:    wdata = {partial[15:0], PAD_BYTE, 8'h0};
          default: wdata = {partial, PAD_BYTE};
        endcase
      end else if (pad_idx == 4'd14 && !(fill >= 6'd56 && !len_block)) begin
        wdata = bit_len[63:32];
      end else if (pad_idx == 4'd15 && !(fill >= 6'd56 && !len_block)) begin
        wdata = bit_len[31:0];
      end else begin
        wdata = '0;
      end
    end
    if (state == ST_PRE) begin
      raddr = '0;
    end
    if (state == ST_RND) begin
      raddr = AW'(rnd[3:0] + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill          <= '0;
      msg_len       <= '0;
      final_pending <= 1'b0;
      len_block     <= 1'b0;
      pad_idx       <= '0;
      out_idx       <= '0;
      rnd           <= '0;
      for (int i = 0; i < CHAIN_WORDS; i++) chain[i] <= INIT_H[i];
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (has_byte) begin
              fill    <= fill + 6'd1;
              msg_len <= msg_len + 64'd1;
              partial <= byte_word[23:0];
            end
            final_pending <= end_of_message;
            if (has_byte && fill == 6'd63) begin
              state <= ST_PRE;
            end else if (end_of_message) begin
              len_block <= 1'b0;
              pad_idx   <= has_byte ? (fill[5:2] + {3'b0, fill[1:0] == 2'b11}) : fill[5:2];
              state     <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_idx == 4'd15) begin
            state <= ST_PRE;
          end else begin
            pad_idx <= pad_idx + 4'd1;
          end
        end
        ST_PRE: begin
          rnd <= '0;
          va <= chain[0]; vb <= chain[1]; vc <= chain[2]; vd <= chain[3];
          ve <= chain[4]; vf <= chain[5]; vg <= chain[6]; vh <= chain[7];
          state <= ST_RND;
        end
        ST_RND: begin
          for (int i = 0; i < BLOCK_WORDS - 1; i++) w_hist[i] <= w_hist[i+1];
          w_hist[BLOCK_WORDS-1] <= w_cur;
          vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
          vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
          rnd <= rnd + 7'd1;
          if (rnd == 7'(ROUNDS - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain[0] <= chain[0] + va; chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc; chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve; chain[5] <= chain[5] + vf;
          chain[6] <= chain[6] + vg; chain[7] <= chain[7] + vh;
          if (!final_pending) begin
            state <= ST_IDLE;
          end else if (!len_block && fill >= 6'd56) begin
            len_block <= 1'b1;
            pad_idx   <= '0;
            state     <= ST_PAD;
          end else if (!len_block && fill == 6'd0 && !pad_done_flag) begin
            len_block <= 1'b0;
            pad_idx   <= '0;
            state     <= ST_PAD;
          end else begin
            out_idx <= '0;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == 2'd3) begin
              state <= ST_LAST;
            end
          end
        end
        ST_LAST: begin
          for (int i = 0; i < CHAIN_WORDS; i++) chain[i] <= INIT_H[i];
          fill          <= '0;
          msg_len       <= '0;
          final_pending <= 1'b0;
          len_block     <= 1'b0;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A full block that ends the message must still get its padding block.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_done_flag <= 1'b0;
    end else if (state == ST_PAD) begin
      pad_done_flag <= 1'b1;
    end else if (state == ST_IDLE) begin
      pad_done_flag <= 1'b0;
    end
  end

  assign out_valid   = (state == ST_OUT);
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 2'd3);
  assign digest_word = {chain[{out_idx, 1'b0}], chain[{out_idx, 1'b1}]};

  `ASSERT_IMPL(a_no_in_when_out, clk, rst, out_valid, in_stall,
               "Input taken while a digest is pending.")
  `ASSERT_IMPL(a_last_is_three, clk, rst, out_valid && last_word, word_index == 2'd3,
               "Last word flag away from word three.")
  `ASSERT_ALWAYS(a_onehot, clk, rst, $onehot(state), "State register not one-hot.")
endmodule

>>> hdl/sha_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
